// File: hdl/espe_pkg.sv
// ----------------------------------------------------------------------------
// espe_pkg
// Shared widths, register map and reset values of the encoder speed and
// position estimator.
// ----------------------------------------------------------------------------
package espe_pkg;

  localparam int VEL_W    = 32;
  localparam int POS_W    = 48;
  localparam int TICK_W   = 18;
  localparam int CNT_IN_W = 16;
  localparam int REG_W    = 32;
  localparam int ADDR_W   = 3;

  typedef logic [REG_W-1:0] reg_word_t;
  typedef logic signed [VEL_W-1:0] vel_t;
  typedef logic signed [POS_W-1:0] pos_t;

  localparam logic REG_SPEED_GAIN    = 1'b0;
  localparam logic REG_SAMPLE_PERIOD = 1'b1;

  localparam reg_word_t GAIN_RST   = 32'd65536;
  localparam reg_word_t PERIOD_RST = 32'd4294967;

  localparam vel_t VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam vel_t VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
  localparam pos_t POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam pos_t POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

endpackage

// File: hdl/encoder_speed_position_estimator.sv
// ----------------------------------------------------------------------------
// encoder_speed_position_estimator
// A sample item passes the states DELTA, MUL1, SUM, AVG, MUL2, ACC and DONE
// before out_valid rises; a reset item passes DELTA and DONE. One item at a
// time: a new item is taken only in IDLE, and the sequencer runs both products
// through one multiplier; a result left waiting holds off the next item.
// Reset (rst_n, synchronous) clears estimator state and loads register
// defaults; the averaging ring is cleared through per-entry valid bits.
// ----------------------------------------------------------------------------
module encoder_speed_position_estimator
  import espe_pkg::*;
#(
  parameter int AVG_WINDOW = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_action,
  input  logic [CNT_IN_W-1:0]        in_counter,
  input  logic                       in_wrapped,
  input  logic                       in_wrap_up,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [VEL_W-1:0]    out_velocity,
  output logic signed [POS_W-1:0]    out_position,
  output logic signed [TICK_W-1:0]   out_tick_delta,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [REG_W-1:0]           pwdata,
  output logic [REG_W-1:0]           prdata,
  output logic                       pready
);

  localparam int DW     = COUNT_BITS + 2;
  localparam int LOG_W  = $clog2(AVG_WINDOW);
  localparam int SLOT_W = (LOG_W > 0) ? LOG_W : 1;
  localparam int SUM_W  = VEL_W + LOG_W;
  localparam int MA_W   = (DW > VEL_W) ? DW : VEL_W;
  localparam int MB_W   = REG_W + 1;
  localparam int PW     = MA_W + MB_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DELTA = 3'd1;
  localparam logic [2:0] S_MUL1  = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_AVG   = 3'd4;
  localparam logic [2:0] S_MUL2  = 3'd5;
  localparam logic [2:0] S_ACC   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic signed [DW-1:0]    RANGE    = DW'(1) << COUNT_BITS;
  localparam logic [SLOT_W-1:0]       SLOT_END = SLOT_W'(AVG_WINDOW - 1);
  localparam logic [SUM_W:0]          AVG_BIAS = (SUM_W+1)'(AVG_WINDOW - 1);

  logic [2:0] state_r;

  reg_word_t gain_r;
  reg_word_t period_r;

  logic                    action_r;
  logic [COUNT_BITS-1:0]   cur_r;
  logic                    wrapped_r;
  logic                    wrap_up_r;

  logic [COUNT_BITS-1:0]   last_r;
  logic                    first_r;
  logic [SLOT_W-1:0]       slot_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [POS_W-1:0] acc_r;
  logic signed [DW-1:0]    delta_r;
  logic signed [VEL_W-1:0] avg_r;

  logic signed [VEL_W-1:0] ring_mem [AVG_WINDOW];
  logic signed [VEL_W-1:0] ring_rd_r;
  logic [AVG_WINDOW-1:0]   ring_vld_r;

  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [PW-1:0]    prod_r;

  logic signed [DW-1:0]    diff;
  logic signed [DW-1:0]    delta_nxt;
  logic signed [VEL_W-1:0] inst;
  logic signed [VEL_W-1:0] ring_old;
  logic signed [SUM_W:0]   sum_nxt;
  logic signed [SUM_W:0]   sum_biased;
  logic signed [VEL_W-1:0] avg_nxt;
  logic signed [PW:0]      rnd;
  logic signed [PW-32:0]   inc;
  logic signed [POS_W:0]   pos_sum;
  logic signed [POS_W-1:0] acc_nxt;

  logic                    out_valid_r;
  logic signed [VEL_W-1:0] out_vel_r;
  logic signed [POS_W-1:0] out_pos_r;
  logic signed [TICK_W-1:0] out_tick_r;

  logic cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_SAMPLE_PERIOD) ? period_r : gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RST;
      period_r <= PERIOD_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SPEED_GAIN) begin
        gain_r <= pwdata;
      end else begin
        period_r <= pwdata;
      end
    end
  end

  // datapath
  always_comb begin
    diff = DW'(cur_r) - DW'(last_r);
    if (first_r || cur_r == last_r) begin
      delta_nxt = '0;
    end else if (wrapped_r && wrap_up_r) begin
      delta_nxt = diff + RANGE;
    end else if (wrapped_r) begin
      delta_nxt = diff - RANGE;
    end else begin
      delta_nxt = diff;
    end
  end

  assign mul_a = (state_r == S_MUL1) ? MA_W'(delta_r) : MA_W'(avg_r);
  assign mul_b = (state_r == S_MUL1) ? $signed({1'b0, gain_r}) : $signed({1'b0, period_r});

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_comb begin
    if (prod_r[PW-1:VEL_W-1] == '0 || prod_r[PW-1:VEL_W-1] == '1) begin
      inst = prod_r[VEL_W-1:0];
    end else if (prod_r[PW-1]) begin
      inst = VEL_MIN;
    end else begin
      inst = VEL_MAX;
    end
  end

  assign ring_old   = ring_vld_r[slot_r] ? ring_rd_r : '0;
  assign sum_nxt    = (SUM_W+1)'(sum_r) - (SUM_W+1)'(ring_old) + (SUM_W+1)'(inst);
  assign sum_biased = (SUM_W+1)'(sum_r) + (sum_r[SUM_W-1] ? AVG_BIAS : '0);
  assign avg_nxt    = VEL_W'(sum_biased >>> LOG_W);

  assign rnd     = (PW+1)'(prod_r) + {{(PW-31){1'b0}}, 1'b1, 31'b0};
  assign inc     = rnd[PW:32];
  assign pos_sum = (POS_W+1)'(acc_r) + (POS_W+1)'(inc);

  always_comb begin
    if (pos_sum[POS_W] != pos_sum[POS_W-1]) begin
      acc_nxt = pos_sum[POS_W] ? POS_MIN : POS_MAX;
    end else begin
      acc_nxt = pos_sum[POS_W-1:0];
    end
  end

  // averaging ring
  always_ff @(posedge clk) begin
    if (state_r == S_DELTA) begin
      ring_rd_r <= ring_mem[slot_r];
    end
    if (state_r == S_SUM) begin
      ring_mem[slot_r] <= inst;
    end
  end

  // item payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      action_r  <= in_action;
      cur_r     <= COUNT_BITS'(in_counter);
      wrapped_r <= in_wrapped;
      wrap_up_r <= in_wrap_up;
    end
  end

  // sequencer
  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= '0;
      first_r     <= 1'b1;
      slot_r      <= '0;
      sum_r       <= '0;
      acc_r       <= '0;
      ring_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_DELTA;
          end
        end
        S_DELTA: begin
          if (action_r) begin
            last_r     <= cur_r;
            first_r    <= 1'b1;
            slot_r     <= '0;
            sum_r      <= '0;
            acc_r      <= '0;
            ring_vld_r <= '0;
            delta_r    <= '0;
            avg_r      <= '0;
            state_r    <= S_DONE;
          end else begin
            delta_r <= delta_nxt;
            first_r <= 1'b0;
            last_r  <= cur_r;
            state_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          state_r <= S_SUM;
        end
        S_SUM: begin
          sum_r              <= sum_nxt[SUM_W-1:0];
          ring_vld_r[slot_r] <= 1'b1;
          slot_r             <= (slot_r == SLOT_END) ? '0 : slot_r + 1'b1;
          state_r            <= S_AVG;
        end
        S_AVG: begin
          avg_r   <= avg_nxt;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r   <= acc_nxt;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_vel_r  <= avg_r;
      out_pos_r  <= acc_r;
      out_tick_r <= TICK_W'(delta_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_velocity   = out_vel_r;
  assign out_position   = out_pos_r;
  assign out_tick_delta = out_tick_r;

endmodule
